>>> design/urb_pkg.sv
// urb_pkg: shared types and codes for the uart receive buffer
// no dependencies; used by urb_ctrl, urb_datapath and uart_receive_buffer
`timescale 1ns / 1ps

package urb_pkg;

   // request action codes
   localparam logic [1:0] ACTION_RECEIVE = 2'd0;
   localparam logic [1:0] ACTION_READ    = 2'd1;
   localparam logic [1:0] ACTION_QUERY   = 2'd2;

   // read status codes
   localparam logic [1:0] STATUS_NORMAL  = 2'd0;
   localparam logic [1:0] STATUS_DRAINED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       has_data;
      logic [1:0] read_status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

>>> design/uart_receive_buffer.sv
// uart_receive_buffer: top level of the uart receive byte buffer
// depends on urb_pkg, urb_ctrl and urb_datapath
`timescale 1ns / 1ps
//
//   channel   ports                       direction  transfer when
//   request   start, busy, req_data       in         start high, busy low
//   result    rsp_strobe, rsp_data        out        rsp_strobe high (one cycle)
//
// for each request the accepting edge loads the request and
// reads the store at the read index, the next edge updates the indices and
// the result register; the result strobe is high in the cycle after that
// busy is high for one cycle per request, so a new request may be given
// while the previous result is on the strobe
// reset clears indices, empty flag and fill mark at once; the store itself
// is not cleared, entries at or above the fill mark read as zero
// the receiver cannot stall results; there is no back-pressure

module uart_receive_buffer #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  urb_pkg::req_type req_data,
   output logic             rsp_strobe,
   output urb_pkg::rsp_type rsp_data
);

   // commands from the sequencer to the datapath
   urb_pkg::cmd_type cmd;

   urb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // store, read and write indices, empty flag, fill mark, result register
   urb_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .req_in  (req_data),
      .rsp_out (rsp_data)
   );

endmodule

>>> design/urb_ctrl.sv
// urb_ctrl: sequencing state machine of the uart receive buffer
// depends on urb_pkg (cmd_type)
`timescale 1ns / 1ps

module urb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output urb_pkg::cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               strobe_ff <= 1'b0;
               if (start) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b1;
            end
            default: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b0;
            end
         endcase
      end
   end

   assign cmd.load   = start && (state_ff == ST_IDLE);
   assign cmd.exec   = (state_ff == ST_EXEC);
   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   // every accepted request is followed by a result strobe once the exec state is through
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> ##2 strobe_ff)
      else $error("result strobe missing after accepted request");

   a_busy_tracks_exec: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff == ST_EXEC))
      else $error("busy out of step with state");

   a_strobe_only_after_exec: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == ST_EXEC))
      else $error("result strobe without an executed request");

endmodule

>>> design/urb_datapath.sv
// urb_datapath: byte store, indices, empty flag, fill mark and result registers
// depends on urb_pkg (req_type, rsp_type, cmd_type, action and status codes)
`timescale 1ns / 1ps

module urb_datapath #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  urb_pkg::cmd_type cmd,
   input  urb_pkg::req_type req_in,
   output urb_pkg::rsp_type rsp_out
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = AW + 1;

   logic [7:0]       mem [DEPTH];
   urb_pkg::req_type req_ff;
   logic [7:0]       rd_word_ff;
   logic [AW-1:0]    widx_ff, widx_in;
   logic [AW-1:0]    ridx_ff, ridx_in;
   logic             empty_ff, empty_in;
   logic [CW-1:0]    fill_ff, fill_in;     // entries below this have been written
   urb_pkg::rsp_type rsp_ff, rsp_in;

   logic [AW-1:0]    widx_eff;
   logic [7:0]       word;
   logic             caught_up;
   logic             do_write;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
      return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
   endfunction

   assign widx_eff  = empty_ff ? '0 : widx_ff;
   assign word      = ({1'b0, ridx_ff} < fill_ff) ? rd_word_ff : 8'd0;
   assign caught_up = (ridx_ff >= widx_ff);
   assign do_write  = cmd.exec && (req_ff.action == urb_pkg::ACTION_RECEIVE);

   always_comb begin
      widx_in  = widx_ff;
      ridx_in  = ridx_ff;
      empty_in = empty_ff;
      fill_in  = fill_ff;
      rsp_in.read_data   = 8'd0;
      rsp_in.read_status = urb_pkg::STATUS_NORMAL;
      case (req_ff.action)
         urb_pkg::ACTION_RECEIVE: begin
            widx_in = widx_eff;
            if ({1'b0, widx_eff} == fill_ff) fill_in = fill_ff + CW'(1);
            if (req_ff.rx_byte != 8'd0) begin
               empty_in = 1'b0;
               widx_in  = advance(widx_eff);
            end
         end
         urb_pkg::ACTION_READ: begin
            if (caught_up) begin
               rsp_in.read_data   = word;
               rsp_in.read_status = urb_pkg::STATUS_DRAINED;
               widx_in  = '0;
               ridx_in  = '0;
               empty_in = 1'b1;
            end else if (!empty_ff) begin
               rsp_in.read_data = word;
               ridx_in = advance(ridx_ff);
            end else begin
               rsp_in.read_status = urb_pkg::STATUS_EMPTY;
            end
         end
         urb_pkg::ACTION_QUERY: begin
            if (caught_up) begin
               widx_in  = '0;
               ridx_in  = '0;
               empty_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_in.has_data = !empty_in;
   end

   // store: a write in the exec of a receive request, a registered read when a request is loaded
   always_ff @(posedge clock) begin
      if (do_write) mem[widx_eff] <= req_ff.rx_byte;
      if (cmd.load) rd_word_ff <= mem[ridx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_in;
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff  <= '0;
         ridx_ff  <= '0;
         empty_ff <= 1'b1;
         fill_ff  <= '0;
      end else if (cmd.exec) begin
         widx_ff  <= widx_in;
         ridx_ff  <= ridx_in;
         empty_ff <= empty_in;
         fill_ff  <= fill_in;
      end
   end

   assign rsp_out = rsp_ff;

   a_empty_means_cleared: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (widx_ff == '0) && (ridx_ff == '0))
      else $error("empty buffer with nonzero index");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= CW'(DEPTH)) && ({1'b0, widx_ff} <= fill_ff))
      else $error("fill mark out of range");

endmodule

>>> verif/tb_uart_receive_buffer.sv
// tb_uart_receive_buffer: self-checking testbench for the uart receive byte buffer
// depends on urb_pkg and uart_receive_buffer; predicts every response and compares in order
`timescale 1ns / 1ps

module tb_uart_receive_buffer;

   localparam int DEPTH        = 256;
   localparam int NUM_RANDOM   = 500;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 8;

   // action code 3 has no meaning in the block; it must leave the state alone
   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   // running prediction of the buffer plus the queue of responses still owed
   class rx_buffer_predictor;
      logic [7:0]       store [DEPTH];
      int               wr_idx;
      int               rd_idx;
      bit               empty;
      urb_pkg::rsp_type expected_rsp [$];
      int               mismatches;

      function new();
         foreach (store[i]) store[i] = 8'h00;
         wr_idx     = 0;
         rd_idx     = 0;
         empty      = 1'b1;
         mismatches = 0;
      endfunction

      // work out the response of one accepted request and move the state on
      function void note_request(urb_pkg::req_type req);
         urb_pkg::rsp_type rsp;
         rsp = '0;
         rsp.read_status = urb_pkg::STATUS_NORMAL;
         case (req.action)
            urb_pkg::ACTION_RECEIVE: begin
               if (empty) wr_idx = 0;
               store[wr_idx] = req.rx_byte;
               // a zero byte is stored but neither clears the empty flag nor advances
               if (req.rx_byte != 8'h00) begin
                  empty  = 1'b0;
                  wr_idx = (wr_idx + 1) % DEPTH;
               end
            end
            urb_pkg::ACTION_READ: begin
               if (rd_idx >= wr_idx) begin
                  // read index caught up: hand out the byte and drain
                  rsp.read_data   = store[rd_idx];
                  rsp.read_status = urb_pkg::STATUS_DRAINED;
                  rd_idx = 0;
                  wr_idx = 0;
                  empty  = 1'b1;
               end else if (!empty) begin
                  rsp.read_data = store[rd_idx];
                  rd_idx = (rd_idx + 1) % DEPTH;
               end else begin
                  rsp.read_status = urb_pkg::STATUS_EMPTY;
               end
            end
            urb_pkg::ACTION_QUERY: begin
               if (rd_idx >= wr_idx) begin
                  rd_idx = 0;
                  wr_idx = 0;
                  empty  = 1'b1;
               end
            end
            default: ;
         endcase
         rsp.has_data = !empty;
         expected_rsp.push_back(rsp);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_response(urb_pkg::rsp_type got);
         urb_pkg::rsp_type exp;
         if (expected_rsp.size() == 0) begin
            report($sformatf("response with none outstanding: %p", got));
            return;
         end
         exp = expected_rsp.pop_front();
         if (got.read_data !== exp.read_data)
            report($sformatf("read_data %h, predicted %h", got.read_data, exp.read_data));
         if (got.has_data !== exp.has_data)
            report($sformatf("has_data %b, predicted %b", got.has_data, exp.has_data));
         if (got.read_status !== exp.read_status)
            report($sformatf("read_status %0d, predicted %0d",
                             got.read_status, exp.read_status));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   urb_pkg::req_type req_data;
   logic             rsp_strobe;
   urb_pkg::rsp_type rsp_data;

   rx_buffer_predictor buf_pred;
   int cycles;
   int bytes_sent;   // counts requests that do something, unused code excluded

   uart_receive_buffer #(
      .DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cycle count and the overall time limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_uart_receive_buffer failed");
         $finish;
      end
   end

   // response side: every strobe is a transfer, there is no way to hold it off
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         buf_pred.check_response(rsp_data);
   end

   // present one request from the falling edge and hold it until a rising
   // edge sees start high with busy low; start stays high for a back-to-back request
   task send_request(logic [1:0] action, logic [7:0] rx_byte);
      urb_pkg::req_type item;
      item.action  = action;
      item.rx_byte = rx_byte;
      @(negedge clock);
      start    = 1'b1;
      req_data = item;
      @(posedge clock);
      while (busy) @(posedge clock);
      buf_pred.note_request(item);
      if (action != ACTION_UNUSED) bytes_sent++;
   endtask

   // idle the request side; mostly no gap, often a short one, now and then a long one
   task idle_gap(bit no_gaps);
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 55) len = 0;
      else if (pick < 92) len = $urandom_range(1, 3);
      else len = $urandom_range(10, 30);
      if (len > 0) begin
         @(negedge clock);
         start            = 1'b0;
         // junk while idle, must be ignored
         req_data.action  = 2'($urandom);
         req_data.rx_byte = 8'($urandom);
         repeat (len - 1) @(negedge clock);
      end
   endtask

   // hold off the sender until every response owed has come back
   task wait_all_responses();
      @(negedge clock);
      start = 1'b0;
      while (buf_pred.expected_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_byte();
      // zero bytes often enough to hit the no-advance path
      if ($urandom_range(0, 9) == 0) return 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   task send_and_idle(logic [1:0] action, logic [7:0] rx_byte, bit no_gaps);
      send_request(action, rx_byte);
      idle_gap(no_gaps);
   endtask

   initial begin
      int  seg;
      int  burst;
      int  reads;
      int  wrap_at;
      bit  wrapped;
      bit  no_gaps;

      buf_pred   = new();
      cycles     = 0;
      bytes_sent = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed: zero byte, extremes of the byte, all actions, catch-up reads
      send_and_idle(urb_pkg::ACTION_RECEIVE, 8'h00, 1'b0);  // zero byte into empty buffer
      send_and_idle(urb_pkg::ACTION_QUERY,   8'h00, 1'b0);
      send_and_idle(urb_pkg::ACTION_READ,    8'h00, 1'b0);  // catch-up read while empty
      send_and_idle(urb_pkg::ACTION_RECEIVE, 8'hFF, 1'b1);
      send_and_idle(urb_pkg::ACTION_RECEIVE, 8'h01, 1'b1);
      send_and_idle(urb_pkg::ACTION_RECEIVE, 8'h80, 1'b1);
      send_and_idle(urb_pkg::ACTION_RECEIVE, 8'h00, 1'b0);  // zero byte stored, index held
      send_and_idle(urb_pkg::ACTION_QUERY,   8'hFF, 1'b0);
      send_and_idle(urb_pkg::ACTION_READ,    8'hFF, 1'b1);
      send_and_idle(urb_pkg::ACTION_READ,    8'h00, 1'b1);
      send_and_idle(urb_pkg::ACTION_READ,    8'h00, 1'b1);
      send_and_idle(urb_pkg::ACTION_READ,    8'h00, 1'b0);  // read index caught up, drains
      send_and_idle(urb_pkg::ACTION_QUERY,   8'h00, 1'b0);
      send_and_idle(ACTION_UNUSED,           8'hAA, 1'b0);  // unused code, no state change
      send_and_idle(urb_pkg::ACTION_RECEIVE, 8'h55, 1'b0);
      send_and_idle(ACTION_UNUSED,           8'h55, 1'b1);
      send_and_idle(urb_pkg::ACTION_QUERY,   8'hAA, 1'b1);
      send_and_idle(urb_pkg::ACTION_READ,    8'h00, 1'b1);
      send_and_idle(urb_pkg::ACTION_READ,    8'h00, 1'b0);
      send_and_idle(urb_pkg::ACTION_RECEIVE, 8'hAA, 1'b0);
      send_and_idle(urb_pkg::ACTION_QUERY,   8'h00, 1'b0);  // query short of catch-up, no drain
      send_and_idle(urb_pkg::ACTION_READ,    8'h00, 1'b0);
      wait_all_responses();

      // random: mostly fill-then-read runs, some noise, one run long enough
      // to wrap the write index
      bytes_sent = 0;
      wrapped    = 1'b0;
      wrap_at    = $urandom_range(40, 240);
      while (bytes_sent < NUM_RANDOM) begin
         seg     = $urandom_range(0, 99);
         no_gaps = ($urandom_range(0, 3) == 0);
         if (!wrapped && bytes_sent >= wrap_at) begin
            // past the last entry the write index wraps; a read drains once the read index is at or past it
            burst = DEPTH + $urandom_range(0, 8);
            repeat (burst)
               send_and_idle(urb_pkg::ACTION_RECEIVE, 8'($urandom_range(1, 255)), no_gaps);
            reads = $urandom_range(1, 12);
            repeat (reads)
               send_and_idle(urb_pkg::ACTION_READ, 8'($urandom), no_gaps);
            wrapped = 1'b1;
         end else if (seg < 75) begin
            burst = $urandom_range(1, 12);
            repeat (burst)
               send_and_idle(urb_pkg::ACTION_RECEIVE, random_byte(), no_gaps);
            reads = $urandom_range(0, burst + 2);
            repeat (reads) begin
               if ($urandom_range(0, 4) == 0)
                  send_and_idle(urb_pkg::ACTION_QUERY, 8'($urandom), no_gaps);
               else
                  send_and_idle(urb_pkg::ACTION_READ, 8'($urandom), no_gaps);
            end
         end else if (seg < 94) begin
            burst = $urandom_range(1, 6);
            repeat (burst)
               send_and_idle(2'($urandom), random_byte(), no_gaps);
         end else begin
            wait_all_responses();
         end
      end

      // let the last responses arrive, then keep watching for stray strobes
      @(negedge clock);
      start = 1'b0;
      while (buf_pred.expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (buf_pred.mismatches == 0) begin
         $display("tb_uart_receive_buffer passed");
      end else begin
         $display("tb_uart_receive_buffer failed");
      end
      $finish;
   end

endmodule
